>>> rtl/udbf_pkg.sv
// udbf_pkg: opcodes, register indexes, field widths and shared structs
// for the dual byte fifo core; no dependencies
`timescale 1ns / 1ps

package udbf_pkg;

    // field widths of the word interface
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int DRAIN_W = 5;
    localparam int LEVEL_W = 5;

    // configuration port widths
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register indexes (paddr[2])
    localparam logic REG_TX_ENABLE = 1'b0;
    localparam logic REG_RX_ENABLE = 1'b1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_TX  = 3'd0,
        OP_POP_RX   = 3'd1,
        OP_LINE_RX  = 3'd2,
        OP_TX_DRAIN = 3'd3,
        OP_CLR_ERR  = 3'd4,
        OP_FLUSH    = 3'd5
    } t_opcode;

    // qualified commands into the receive fifo
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              flush;
        logic [BYTE_W-1:0] wdata;
    } t_rx_cmd;

endpackage

>>> rtl/uart_dual_byte_fifo_core.sv
// uart_dual_byte_fifo_core: one operation word in, one status word out, one word per cycle while i_ready is high
// path: input register, then result register; a held word executes into the result register
// once that register is free or its word is taken
// throughput: one word per cycle while i_ready is high, set by the single pass over the counts and the rx prefetch
// reset: synchronous active-low, clears levels, pointers, overrun, enables and valid flags
// depends on udbf_pkg, udbf_rx_fifo and udbf_ram; rx byte contents are not cleared
`timescale 1ns / 1ps

module uart_dual_byte_fifo_core import udbf_pkg::*; #(
    parameter int FIFO_SIZE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // operation words
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [BYTE_W-1:0]  i_byte_in,
    input  logic [DRAIN_W-1:0] i_drain_count,
    // status words
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_accepted,
    output logic [BYTE_W-1:0]  o_byte_out,
    output logic [LEVEL_W-1:0] o_tx_level,
    output logic [LEVEL_W-1:0] o_rx_level,
    output logic               o_tx_empty,
    output logic               o_tx_full,
    output logic               o_rx_empty,
    output logic               o_rx_full,
    output logic               o_overrun,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int CW = $clog2(FIFO_SIZE + 1);
    localparam int DW = (CW > DRAIN_W) ? CW : DRAIN_W;

    // input register
    logic               r_in_valid;
    logic [OP_W-1:0]    r_op;
    logic [BYTE_W-1:0]  r_byte;
    logic [DRAIN_W-1:0] r_drain;

    // result register
    logic               r_out_valid;
    logic               r_accepted;
    logic [BYTE_W-1:0]  r_byte_out;
    logic [LEVEL_W-1:0] r_tx_level;
    logic [LEVEL_W-1:0] r_rx_level;
    logic               r_tx_empty;
    logic               r_tx_full;
    logic               r_rx_empty;
    logic               r_rx_full;
    logic               r_out_overrun;

    // block state
    logic               r_tx_en;
    logic               r_rx_en;
    logic [CW-1:0]      r_tx_cnt, n_tx_cnt;
    logic               r_overrun, n_overrun;

    logic               w_exec;
    logic               w_push_ok;
    logic               w_pop_ok;
    logic               w_recv_ok;
    logic               n_accepted;
    logic [DW-1:0]      w_drain_ext;
    logic [DW-1:0]      w_tx_cnt_ext;
    logic [DW-1:0]      w_take;
    logic               w_cfg_wr;
    t_rx_cmd            w_rx_cmd;
    logic [CW-1:0]      w_rx_cnt;
    logic [CW-1:0]      w_rx_next_cnt;
    logic [BYTE_W-1:0]  w_rx_rdata;

    // handshake: the held word executes when the result register is free
    assign w_exec  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_exec;

    // drain amount is the smaller of the request and the tx level
    assign w_drain_ext  = DW'(r_drain);
    assign w_tx_cnt_ext = DW'(r_tx_cnt);
    assign w_take       = (w_drain_ext < w_tx_cnt_ext) ? w_drain_ext : w_tx_cnt_ext;

    // operation decode and state next values
    always_comb begin
        w_push_ok = 1'b0;
        w_pop_ok  = 1'b0;
        w_recv_ok = 1'b0;
        n_tx_cnt  = r_tx_cnt;
        n_overrun = r_overrun;
        w_rx_cmd  = '{push: 1'b0, pop: 1'b0, flush: 1'b0, wdata: r_byte};
        case (r_op)
            OP_PUSH_TX: begin
                w_push_ok = r_tx_en && (r_tx_cnt != CW'(FIFO_SIZE));
                if (w_push_ok) begin
                    n_tx_cnt = r_tx_cnt + 1'b1;
                end
            end
            OP_POP_RX: begin
                w_pop_ok = r_rx_en && (w_rx_cnt != '0);
            end
            OP_LINE_RX: begin
                if (r_rx_en) begin
                    if (w_rx_cnt == CW'(FIFO_SIZE)) begin
                        n_overrun = 1'b1;
                    end else begin
                        w_recv_ok = 1'b1;
                    end
                end
            end
            OP_TX_DRAIN: begin
                if (r_tx_en) begin
                    n_tx_cnt = CW'(w_tx_cnt_ext - w_take);
                end
            end
            OP_CLR_ERR: begin
                n_overrun = 1'b0;
            end
            OP_FLUSH: begin
                n_tx_cnt       = '0;
                w_rx_cmd.flush = w_exec;
            end
            default: begin
            end
        endcase
        w_rx_cmd.push = w_exec && w_recv_ok;
        w_rx_cmd.pop  = w_exec && w_pop_ok;
    end

    assign n_accepted = w_push_ok || w_pop_ok || w_recv_ok;

    // receive fifo
    udbf_rx_fifo #(
        .FIFO_SIZE (FIFO_SIZE)
    ) u_rx_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_rx_cmd),
        .o_count      (w_rx_cnt),
        .o_next_count (w_rx_next_cnt),
        .o_rdata      (w_rx_rdata)
    );

    // configuration writes
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_TX_ENABLE: prdata[0] = r_tx_en;
            REG_RX_ENABLE: prdata[0] = r_rx_en;
            default:       prdata    = '0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tx_cnt    <= '0;
            r_overrun   <= 1'b0;
            r_tx_en     <= 1'b0;
            r_rx_en     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
                r_tx_cnt    <= n_tx_cnt;
                r_overrun   <= n_overrun;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                case (paddr[2])
                    REG_TX_ENABLE: r_tx_en <= pwdata[0];
                    REG_RX_ENABLE: r_rx_en <= pwdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op    <= i_opcode;
            r_byte  <= i_byte_in;
            r_drain <= i_drain_count;
        end
        if (w_exec) begin
            r_accepted    <= n_accepted;
            r_byte_out    <= w_pop_ok ? w_rx_rdata : '0;
            r_tx_level    <= LEVEL_W'(n_tx_cnt);
            r_rx_level    <= LEVEL_W'(w_rx_next_cnt);
            r_tx_empty    <= (n_tx_cnt == '0);
            r_tx_full     <= (n_tx_cnt == CW'(FIFO_SIZE));
            r_rx_empty    <= (w_rx_next_cnt == '0);
            r_rx_full     <= (w_rx_next_cnt == CW'(FIFO_SIZE));
            r_out_overrun <= n_overrun;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_accepted = r_accepted;
    assign o_byte_out = r_byte_out;
    assign o_tx_level = r_tx_level;
    assign o_rx_level = r_rx_level;
    assign o_tx_empty = r_tx_empty;
    assign o_tx_full  = r_tx_full;
    assign o_rx_empty = r_rx_empty;
    assign o_rx_full  = r_rx_full;
    assign o_overrun  = r_out_overrun;

`ifndef SYNTH
    // a flush leaves both levels at zero in its result
    a_flush_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && (r_op == OP_FLUSH)) |=> (r_tx_level == '0) && (r_rx_level == '0))
        else $error("flush result shows nonzero level");

    // an accepted push raises the tx level by exactly one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && w_push_ok) |=> (r_tx_cnt == $past(r_tx_cnt) + 1'b1))
        else $error("tx level not advanced by accepted push");

    // overrun only rises on a line receive
    a_overrun_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_overrun) |-> $past(w_exec && (r_op == OP_LINE_RX)))
        else $error("overrun set outside a line receive");
`endif

endmodule

>>> rtl/udbf_ram.sv
// udbf_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module udbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read returns old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/udbf_rx_fifo.sv
// udbf_rx_fifo: receive byte fifo, pointers and level around a udbf_ram
// depends on udbf_pkg and udbf_ram
`timescale 1ns / 1ps

module udbf_rx_fifo import udbf_pkg::*; #(
    parameter int FIFO_SIZE = 16,
    localparam int PW       = $clog2(FIFO_SIZE),
    localparam int CW       = $clog2(FIFO_SIZE + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rx_cmd           i_cmd,
    output logic [CW-1:0]     o_count,
    output logic [CW-1:0]     o_next_count,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count, n_count;
    logic              r_byp, n_byp;
    logic [BYTE_W-1:0] r_byp_data;
    logic [BYTE_W-1:0] w_ram_q;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PW'(FIFO_SIZE - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointer and level updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_cmd.flush) begin
            n_wr_ptr = '0;
            n_rd_ptr = '0;
            n_count  = '0;
        end else if (i_cmd.push) begin
            n_wr_ptr = advance(r_wr_ptr);
            n_count  = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_rd_ptr = advance(r_rd_ptr);
            n_count  = r_count - 1'b1;
        end
    end

    // a write to the entry prefetched at the same edge is forwarded
    assign n_byp = i_cmd.push && (r_wr_ptr == n_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_byp    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_byp    <= n_byp;
        end
        r_byp_data <= i_cmd.wdata;
    end

    // byte store, read address is the next value of the head pointer, so the head byte is prefetched
    udbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_cmd.wdata),
        .i_raddr (n_rd_ptr),
        .o_rdata (w_ram_q)
    );

    assign o_count      = r_count;
    assign o_next_count = n_count;
    assign o_rdata      = r_byp ? r_byp_data : w_ram_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for uart_dual_byte_fifo_core, one operation word in,
// one status word out; depends on udbf_pkg and the core rtl, nothing else

module tb_top;
    import udbf_pkg::*;

    localparam int DEPTH = 16;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_WAIT_LIMIT = 1000;
    localparam logic [OP_W-1:0] OP_SPARE_SIX   = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_SEVEN = 3'd7;

    // one status word as the block reports it
    typedef struct packed {
        logic               accepted;
        logic [BYTE_W-1:0]  byte_out;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
        logic               tx_empty;
        logic               tx_full;
        logic               rx_empty;
        logic               rx_full;
        logic               overrun;
    } t_status;

    // operation mix of a stretch of random words
    typedef enum int {MOOD_FILL, MOOD_EMPTY, MOOD_MIX} t_mood;

    // fifo level predictor and queue of expected status words
    class fifo_status_board;
        bit                tx_on;
        bit                rx_on;
        bit                overrun_sticky;
        int unsigned       tx_fill;
        logic [BYTE_W-1:0] rx_bytes[$];
        t_status           want_q[$];
        int unsigned       errors;

        function void set_enable(logic idx, bit on);
            if (idx == REG_TX_ENABLE) begin
                tx_on = on;
            end else begin
                rx_on = on;
            end
        endfunction

        function int unsigned pending();
            return want_q.size();
        endfunction

        // apply one accepted operation word and queue the status it must produce
        function void note_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                logic [DRAIN_W-1:0] cnt);
            t_status     s;
            int unsigned take;
            s = '0;
            case (op)
                OP_PUSH_TX: begin
                    if (tx_on && tx_fill < DEPTH) begin
                        tx_fill++;
                        s.accepted = 1'b1;
                    end
                end
                OP_POP_RX: begin
                    if (rx_on && rx_bytes.size() != 0) begin
                        s.byte_out = rx_bytes.pop_front();
                        s.accepted = 1'b1;
                    end
                end
                OP_LINE_RX: begin
                    if (rx_on) begin
                        if (rx_bytes.size() == DEPTH) begin
                            overrun_sticky = 1'b1;
                        end else begin
                            rx_bytes.push_back(data);
                            s.accepted = 1'b1;
                        end
                    end
                end
                OP_TX_DRAIN: begin
                    if (tx_on) begin
                        take = (cnt < tx_fill) ? cnt : tx_fill;
                        tx_fill -= take;
                    end
                end
                OP_CLR_ERR: begin
                    overrun_sticky = 1'b0;
                end
                OP_FLUSH: begin
                    tx_fill = 0;
                    rx_bytes.delete();
                end
                default: begin
                end
            endcase
            s.tx_level = LEVEL_W'(tx_fill);
            s.rx_level = LEVEL_W'(rx_bytes.size());
            s.tx_empty = (tx_fill == 0);
            s.tx_full  = (tx_fill == DEPTH);
            s.rx_empty = (rx_bytes.size() == 0);
            s.rx_full  = (rx_bytes.size() == DEPTH);
            s.overrun  = overrun_sticky;
            want_q.push_back(s);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        // compare one received status word with the oldest expectation
        function void check_status(t_status got);
            t_status want;
            if (want_q.size() == 0) begin
                errors++;
                $display("%0t: status word with nothing expected, actual %p", $time, got);
                return;
            end
            want = want_q.pop_front();
            compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
            compare_field("byte_out", 32'(want.byte_out), 32'(got.byte_out));
            compare_field("tx_level", 32'(want.tx_level), 32'(got.tx_level));
            compare_field("rx_level", 32'(want.rx_level), 32'(got.rx_level));
            compare_field("tx_empty", 32'(want.tx_empty), 32'(got.tx_empty));
            compare_field("tx_full",  32'(want.tx_full),  32'(got.tx_full));
            compare_field("rx_empty", 32'(want.rx_empty), 32'(got.rx_empty));
            compare_field("rx_full",  32'(want.rx_full),  32'(got.rx_full));
            compare_field("overrun",  32'(want.overrun),  32'(got.overrun));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [OP_W-1:0]    i_opcode;
    logic [BYTE_W-1:0]  i_byte_in;
    logic [DRAIN_W-1:0] i_drain_count;
    logic               o_valid;
    logic               i_ready;
    logic               o_accepted;
    logic [BYTE_W-1:0]  o_byte_out;
    logic [LEVEL_W-1:0] o_tx_level;
    logic [LEVEL_W-1:0] o_rx_level;
    logic               o_tx_empty;
    logic               o_tx_full;
    logic               o_rx_empty;
    logic               o_rx_full;
    logic               o_overrun;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    fifo_status_board board;
    bit               hold_req;

    uart_dual_byte_fifo_core #(
        .FIFO_SIZE(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_byte_in    (i_byte_in),
        .i_drain_count(i_drain_count),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_accepted   (o_accepted),
        .o_byte_out   (o_byte_out),
        .o_tx_level   (o_tx_level),
        .o_rx_level   (o_rx_level),
        .o_tx_empty   (o_tx_empty),
        .o_tx_full    (o_tx_full),
        .o_rx_empty   (o_rx_empty),
        .o_rx_full    (o_rx_full),
        .o_overrun    (o_overrun),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // offer one operation word and hold it until the block takes it
    task automatic send_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                             logic [DRAIN_W-1:0] cnt);
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_byte_in     <= data;
        i_drain_count <= cnt;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        board.note_word(op, data, cnt);
    endtask

    task automatic idle_sender(int unsigned n);
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending until every expected status word is back
    task automatic wait_drained();
        idle_sender(1);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(logic idx, bit on);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, on};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_enable(idx, on);
    endtask

    // one random word, operation weighted by the current mood
    task automatic send_random(t_mood mood);
        int unsigned        roll;
        logic [OP_W-1:0]    op;
        logic [DRAIN_W-1:0] cnt;
        roll = $urandom_range(0, 99);
        case (mood)
            MOOD_FILL: begin
                op = (roll < 45) ? OP_PUSH_TX : (roll < 90) ? OP_LINE_RX :
                     (roll < 94) ? OP_POP_RX : (roll < 96) ? OP_TX_DRAIN :
                     (roll < 99) ? OP_CLR_ERR : OP_FLUSH;
            end
            MOOD_EMPTY: begin
                op = (roll < 45) ? OP_POP_RX : (roll < 80) ? OP_TX_DRAIN :
                     (roll < 86) ? OP_PUSH_TX : (roll < 92) ? OP_LINE_RX :
                     (roll < 97) ? OP_CLR_ERR : (roll < 98) ? OP_FLUSH :
                     (roll < 99) ? OP_SPARE_SIX : OP_SPARE_SEVEN;
            end
            default: begin
                op = (roll < 22) ? OP_PUSH_TX : (roll < 42) ? OP_POP_RX :
                     (roll < 64) ? OP_LINE_RX : (roll < 79) ? OP_TX_DRAIN :
                     (roll < 91) ? OP_CLR_ERR : (roll < 94) ? OP_FLUSH :
                     (roll < 97) ? OP_SPARE_SIX : OP_SPARE_SEVEN;
            end
        endcase
        cnt = ($urandom_range(0, 9) < 7) ? DRAIN_W'($urandom_range(0, 3))
                                         : DRAIN_W'($urandom_range(0, 31));
        send_word(op, BYTE_W'($urandom_range(0, 255)), cnt);
    endtask

    // random bursts with random gaps; the mood holds for a stretch of words
    task automatic run_phase(int unsigned n_words);
        int unsigned sent;
        int unsigned burst;
        int unsigned stretch;
        t_mood       mood;
        sent    = 0;
        stretch = 0;
        mood    = MOOD_MIX;
        while (sent < n_words) begin
            if (stretch == 0) begin
                mood    = t_mood'($urandom_range(0, 2));
                stretch = $urandom_range(40, 120);
            end
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                send_random(mood);
                sent++;
                if (stretch != 0) stretch--;
            end
            idle_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
        end
    endtask

    // status side: check accepted words, stall on a pattern of its own
    initial begin : status_sink
        int unsigned run_left;
        int unsigned hold_left;
        bit          stall;
        run_left  = 0;
        hold_left = 0;
        stall     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready === 1'b1) begin
                board.check_status({o_accepted, o_byte_out, o_tx_level, o_rx_level,
                                    o_tx_empty, o_tx_full, o_rx_empty, o_rx_full,
                                    o_overrun});
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    stall    = ($urandom_range(0, 3) == 0);
                    run_left = stall ? $urandom_range(1, 6) : $urandom_range(1, 40);
                end
                run_left--;
                i_ready <= !stall;
            end
        end
    end

    // main sequence
    initial begin : stimulus
        bit          tx_plan [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        bit          rx_plan [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        int unsigned size_plan [6] = '{400, 200, 200, 400, 100, 340};
        int unsigned waited;
        board         = new();
        hold_req      = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_opcode      <= OP_PUSH_TX;
        i_byte_in     <= '0;
        i_drain_count <= '0;
        i_ready       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // both paths disabled after reset: everything refused or ignored
        send_word(OP_PUSH_TX, 8'hFF, 5'd0);
        send_word(OP_POP_RX, 8'h00, 5'd0);
        send_word(OP_LINE_RX, 8'h00, 5'd0);
        send_word(OP_TX_DRAIN, 8'h00, 5'd31);
        send_word(OP_CLR_ERR, 8'h00, 5'd0);
        send_word(OP_FLUSH, 8'h00, 5'd0);
        send_word(OP_SPARE_SIX, 8'h00, 5'd0);
        send_word(OP_SPARE_SEVEN, 8'hFF, 5'd31);
        wait_drained();
        write_reg(REG_TX_ENABLE, 1'b1);
        write_reg(REG_RX_ENABLE, 1'b1);

        // byte extremes, pop of an empty fifo, drains, clear and flush
        send_word(OP_PUSH_TX, 8'h00, 5'd0);
        send_word(OP_PUSH_TX, 8'hFF, 5'd31);
        send_word(OP_LINE_RX, 8'hFF, 5'd0);
        idle_sender(2);
        send_word(OP_LINE_RX, 8'h00, 5'd0);
        send_word(OP_POP_RX, 8'h00, 5'd0);
        send_word(OP_POP_RX, 8'h00, 5'd0);
        send_word(OP_POP_RX, 8'h00, 5'd0);
        send_word(OP_TX_DRAIN, 8'h00, 5'd0);
        send_word(OP_TX_DRAIN, 8'h00, 5'd31);
        send_word(OP_LINE_RX, 8'h5A, 5'd0);
        send_word(OP_CLR_ERR, 8'h00, 5'd0);
        send_word(OP_FLUSH, 8'h00, 5'd0);
        send_word(OP_POP_RX, 8'h00, 5'd0);
        send_word(OP_SPARE_SEVEN, 8'h00, 5'd0);

        // status side holds off while words keep coming, so the input backs up
        hold_req = 1'b1;
        repeat (60) send_random(MOOD_FILL);
        wait_drained();

        // random phases, each under its own enable setting
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_reg(REG_TX_ENABLE, tx_plan[p]);
            write_reg(REG_RX_ENABLE, rx_plan[p]);
            run_phase(size_plan[p]);
        end

        // let the last status words come back
        idle_sender(1);
        waited = 0;
        while (board.pending() != 0 && waited < DRAIN_WAIT_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d status words never arrived", $time, board.pending());
            board.errors += board.pending();
        end
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
